// File: rtl/dro_pkg.sv
// Shared types, constants and calendar helpers for the DST offset calculator.
package dro_pkg;

    localparam logic [31:0] DAY_SECS     = 32'd86400;
    localparam logic [31:0] HOUR_SECS    = 32'd3600;
    localparam logic signed [16:0] MIN_SECS = 17'sd60;
    // Rounded-up 2^35 / 675; the seconds shifted right by seven, times this, shifted right
    // by 35 give the exact day count for every 32-bit time.
    localparam logic [25:0] DAY_RECIP    = 26'd50903317;
    localparam logic [2:0]  EPOCH_WDAY   = 3'd4;
    localparam logic [1:0]  LEAP_PHASE   = 2'd2;
    localparam logic [7:0]  YEAR_NO_LEAP = 8'd130;
    localparam logic [8:0]  YEAR_LEN     = 9'd365;
    localparam logic [8:0]  LEAP_LEN     = 9'd366;
    localparam logic [3:0]  MONTH_MAX    = 4'd12;
    localparam logic [2:0]  WEEK_LAST    = 3'd5;
    localparam logic [2:0]  WDAY_ALIAS   = 3'd7;
    localparam logic [4:0]  FEB_DAYS     = 5'd28;

    typedef struct packed {
        logic [3:0] month;
        logic [2:0] week;
        logic [2:0] wday;
        logic [4:0] hour;
    } t_rule;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [1:0] {
        REG_STD_OFF  = 2'd0,
        REG_DST_MIN  = 2'd1,
        REG_START    = 2'd2,
        REG_END      = 2'd3
    } t_reg_idx;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

endpackage

// File: rtl/dst_rule_offset_calc.sv
// Top level of the DST rule offset calculator with APB registers and sequencer.
//
// Usage: program the standard offset, DST minutes and the start and end rules over the
// APB port while the block is idle. Each transfer on the s_axis channel carries a 32-bit
// Unix UTC time; one transfer on the m_axis channel returns the DST flag and the total
// offset in minutes for that instant.
// One shared 32-bit adder/comparator does the calendar arithmetic under a small sequencer:
// one reciprocal multiply step for the day count, one step per elapsed year since 1970
// (up to 136) plus one, for each rule one step per month up to the rule's month (up to
// twelve) and four more for the rule's instant, and three compares.
// The time from acceptance to a valid result is set mostly by the year count, and a new
// transfer is taken only once the sequencer is back in idle; with DST disabled the
// sequencer goes from acceptance straight to its result state.
// s_axis_tready is high only while the sequencer is idle. The result sits in an output
// register, so a new time may be accepted while the previous result still waits; if the
// receiver stalls, the sequencer holds its finished result until the output register
// frees up.
// Synchronous reset clears the registers to zero and the sequencer to idle.
module dst_rule_offset_calc
    import dro_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] utc_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] dst_active, [11:1] total_offset_min, zeros
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_DIV   = 13'b0000000000010,
        ST_YEAR  = 13'b0000000000100,
        ST_YBASE = 13'b0000000001000,
        ST_MLOOP = 13'b0000000010000,
        ST_PICK  = 13'b0000000100000,
        ST_MUL   = 13'b0000001000000,
        ST_HADD  = 13'b0000010000000,
        ST_OSUB  = 13'b0000100000000,
        ST_CMPS  = 13'b0001000000000,
        ST_CMPE  = 13'b0010000000000,
        ST_CMPO  = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } t_state;

    t_state             r_state, n_state;
    logic signed [10:0] r_std_off;
    logic [6:0]         r_dst_min;
    logic [14:0]        r_start_rule;
    logic [14:0]        r_end_rule;
    logic [31:0]        r_t, n_t;
    logic [31:0]        r_acc, n_acc;
    logic [31:0]        r_ts, n_ts;
    logic [15:0]        r_days, n_days;
    logic [15:0]        r_rem, n_rem;
    logic [15:0]        r_mdays, n_mdays;
    logic [7:0]         r_y, n_y;
    logic [2:0]         r_ywd, n_ywd;
    logic [2:0]         r_wd, n_wd;
    logic [3:0]         r_m, n_m;
    logic               r_sel, n_sel;
    logic               r_ge_s, n_ge_s;
    logic               r_lt_e, n_lt_e;
    logic               r_active, n_active;
    logic               r_ovalid, n_ovalid;
    logic [15:0]        r_odata, n_odata;

    t_rule              w_rule;
    logic [3:0]         w_month;
    logic               w_leap;
    logic [4:0]         w_mlen_cur;
    logic [4:0]         w_mlen_tgt;
    logic [4:0]         w_off;
    logic signed [16:0] w_std_sec;
    logic signed [11:0] w_sum;
    logic [10:0]        w_total;
    logic [50:0]        w_day_prod;
    logic [31:0]        w_alu_a;
    logic [31:0]        w_alu_b;
    t_alu_op            w_alu_op;
    logic [31:0]        w_alu_res;
    logic               w_alu_ge;
    logic               w_wr;

    assign pready        = 1'b1;
    assign w_wr          = psel & penable & pwrite;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_STD_OFF: prdata = {21'd0, r_std_off};
            REG_DST_MIN: prdata = {25'd0, r_dst_min};
            REG_START:   prdata = {17'd0, r_start_rule};
            REG_END:     prdata = {17'd0, r_end_rule};
            default:     prdata = 32'd0;
        endcase
    end

    assign w_rule     = r_sel ? t_rule'(r_end_rule) : t_rule'(r_start_rule);
    assign w_month    = (w_rule.month > MONTH_MAX) ? MONTH_MAX : w_rule.month;
    assign w_leap     = (r_y[1:0] == LEAP_PHASE) && (r_y != YEAR_NO_LEAP);
    assign w_mlen_cur = month_len(r_m, w_leap);
    assign w_mlen_tgt = month_len(w_month, w_leap);
    assign w_std_sec  = $signed({{6{r_std_off[10]}}, r_std_off}) * MIN_SECS;
    assign w_sum      = {r_std_off[10], r_std_off}
                        + (r_active ? $signed({5'd0, r_dst_min}) : 12'sd0);
    assign w_total    = (!w_sum[11] && w_sum[10]) ? 11'h3FF : w_sum[10:0];
    assign w_day_prod = {26'd0, r_t[31:7]} * {25'd0, DAY_RECIP};

    dro_day_pick u_day_pick (
        .i_first_wd (r_wd),
        .i_rule     (w_rule),
        .i_mlen     (w_mlen_tgt),
        .o_off      (w_off)
    );

    dro_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_op  (w_alu_op),
        .o_res (w_alu_res),
        .o_ge  (w_alu_ge)
    );

    always_comb begin
        w_alu_a  = r_acc;
        w_alu_b  = 32'd0;
        w_alu_op = ALU_ADD;
        unique case (r_state)
            ST_YEAR: begin
                w_alu_a  = {16'd0, r_rem};
                w_alu_b  = {23'd0, w_leap ? LEAP_LEN : YEAR_LEN};
                w_alu_op = ALU_SUB;
            end
            ST_YBASE: begin
                w_alu_a  = {16'd0, r_days};
                w_alu_b  = {16'd0, r_rem};
                w_alu_op = ALU_SUB;
            end
            ST_MLOOP: begin
                w_alu_a = {16'd0, r_mdays};
                w_alu_b = {27'd0, w_mlen_cur};
            end
            ST_PICK: begin
                w_alu_a = {16'd0, r_mdays};
                w_alu_b = {27'd0, w_off};
            end
            ST_HADD: begin
                w_alu_b = {27'd0, w_rule.hour} * HOUR_SECS;
            end
            ST_OSUB: begin
                w_alu_b  = {{15{w_std_sec[16]}}, w_std_sec};
                w_alu_op = ALU_SUB;
            end
            ST_CMPS: begin
                w_alu_a  = r_t;
                w_alu_b  = r_ts;
                w_alu_op = ALU_SUB;
            end
            ST_CMPE: begin
                w_alu_a  = r_t;
                w_alu_op = ALU_SUB;
                w_alu_b  = r_acc;
            end
            ST_CMPO: begin
                w_alu_a  = r_ts;
                w_alu_b  = r_acc;
                w_alu_op = ALU_SUB;
            end
            ST_IDLE, ST_DIV, ST_MUL, ST_FIN: begin
                w_alu_b = 32'd0;
            end
            default: begin
                w_alu_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_t      = r_t;
        n_acc    = r_acc;
        n_ts     = r_ts;
        n_days   = r_days;
        n_rem    = r_rem;
        n_mdays  = r_mdays;
        n_y      = r_y;
        n_ywd    = r_ywd;
        n_wd     = r_wd;
        n_m      = r_m;
        n_sel    = r_sel;
        n_ge_s   = r_ge_s;
        n_lt_e   = r_lt_e;
        n_active = r_active;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !m_axis_tready;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_t      = s_axis_tdata;
                    n_acc    = s_axis_tdata;
                    n_active = 1'b0;
                    n_days   = 16'd0;
                    n_state  = (r_dst_min == 7'd0) ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                n_days  = w_day_prod[50:35];
                n_rem   = w_day_prod[50:35];
                n_y     = 8'd0;
                n_ywd   = EPOCH_WDAY;
                n_state = ST_YEAR;
            end
            ST_YEAR: begin
                if (w_alu_ge) begin
                    n_rem = w_alu_res[15:0];
                    n_y   = r_y + 8'd1;
                    n_ywd = wd_add(r_ywd, w_leap ? 3'd2 : 3'd1);
                end else begin
                    n_state = ST_YBASE;
                end
            end
            ST_YBASE: begin
                n_days  = w_alu_res[15:0];
                n_mdays = w_alu_res[15:0];
                n_wd    = r_ywd;
                n_m     = 4'd1;
                n_sel   = 1'b0;
                n_state = ST_MLOOP;
            end
            ST_MLOOP: begin
                if (r_m < w_month) begin
                    n_mdays = w_alu_res[15:0];
                    n_wd    = wd_add(r_wd, 3'(w_mlen_cur - FEB_DAYS));
                    n_m     = r_m + 4'd1;
                end else begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                n_mdays = w_alu_res[15:0];
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_acc   = 32'({16'd0, r_mdays} * DAY_SECS);
                n_state = ST_HADD;
            end
            ST_HADD: begin
                n_acc   = w_alu_res;
                n_state = ST_OSUB;
            end
            ST_OSUB: begin
                if (!r_sel) begin
                    n_ts    = w_alu_res;
                    n_sel   = 1'b1;
                    n_mdays = r_days;
                    n_wd    = r_ywd;
                    n_m     = 4'd1;
                    n_state = ST_MLOOP;
                end else begin
                    n_acc   = w_alu_res;
                    n_state = ST_CMPS;
                end
            end
            ST_CMPS: begin
                n_ge_s  = w_alu_ge;
                n_state = ST_CMPE;
            end
            ST_CMPE: begin
                n_lt_e  = !w_alu_ge;
                n_state = ST_CMPO;
            end
            ST_CMPO: begin
                n_active = !w_alu_ge ? (r_ge_s && r_lt_e) : (r_ge_s || r_lt_e);
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {4'd0, w_total, r_active};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovalid     <= 1'b0;
            r_std_off    <= 11'sd0;
            r_dst_min    <= 7'd0;
            r_start_rule <= 15'd0;
            r_end_rule   <= 15'd0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (w_wr) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_STD_OFF: r_std_off    <= pwdata[10:0];
                    REG_DST_MIN: r_dst_min    <= pwdata[6:0];
                    REG_START:   r_start_rule <= pwdata[14:0];
                    REG_END:     r_end_rule   <= pwdata[14:0];
                    default:     r_dst_min    <= r_dst_min;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_acc    <= n_acc;
        r_ts     <= n_ts;
        r_days   <= n_days;
        r_rem    <= n_rem;
        r_mdays  <= n_mdays;
        r_y      <= n_y;
        r_ywd    <= n_ywd;
        r_wd     <= n_wd;
        r_m      <= n_m;
        r_sel    <= n_sel;
        r_ge_s   <= n_ge_s;
        r_lt_e   <= n_lt_e;
        r_active <= n_active;
        r_odata  <= n_odata;
    end

    a_disabled_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && r_dst_min == 7'd0)
        |=> (r_state == ST_FIN && !r_active))
        else $error("DST-disabled transfer did not go straight to the result");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> (r_state == ST_YEAR))
        else $error("Day count did not hand over to the year count");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_YEAR) |-> (r_y <= 8'd136))
        else $error("Year count ran past the 32-bit time range");

endmodule

// File: rtl/dro_alu.sv
// Shared 32-bit add, subtract and unsigned compare unit.
module dro_alu
    import dro_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  t_alu_op     i_op,
    output logic [31:0] o_res,
    output logic        o_ge
);

    logic [32:0] w_sum;
    logic [31:0] w_b;

    assign w_b   = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign w_sum = {1'b0, i_a} + {1'b0, w_b} + {32'd0, (i_op == ALU_SUB)};
    assign o_res = w_sum[31:0];
    assign o_ge  = w_sum[32];

endmodule

// File: rtl/dro_day_pick.sv
// Day offset within the month of a rule's transition.
module dro_day_pick
    import dro_pkg::*;
(
    input  logic [2:0] i_first_wd,
    input  t_rule      i_rule,
    input  logic [4:0] i_mlen,
    output logic [4:0] o_off
);

    logic [2:0] w_wdn;
    logic [2:0] w_delta;
    logic [5:0] w_d6;
    logic [5:0] w_mlen6;
    logic [2:0] w_week;
    logic [5:0] w_step;
    logic [5:0] w_tgt;

    always_comb begin
        w_wdn   = (i_rule.wday == WDAY_ALIAS) ? 3'd0 : i_rule.wday;
        w_delta = wd_add(w_wdn, (i_first_wd == 3'd0) ? 3'd0 : 3'(3'd7 - i_first_wd));
        w_d6    = {3'd0, w_delta};
        w_mlen6 = {1'b0, i_mlen};
        w_week  = (i_rule.week == 3'd0) ? 3'd1 : i_rule.week;
        w_step  = 6'({3'd0, w_week - 3'd1} * 6'd7);
        w_tgt   = w_d6 + w_step;
        if (i_rule.week == WEEK_LAST) begin
            if (w_d6 + 6'd28 < w_mlen6) begin
                o_off = 5'(w_d6 + 6'd28);
            end else if (w_d6 + 6'd21 < w_mlen6) begin
                o_off = 5'(w_d6 + 6'd21);
            end else if (w_d6 + 6'd14 < w_mlen6) begin
                o_off = 5'(w_d6 + 6'd14);
            end else if (w_d6 + 6'd7 < w_mlen6) begin
                o_off = 5'(w_d6 + 6'd7);
            end else begin
                o_off = 5'(w_d6);
            end
        end else if (w_tgt >= w_mlen6) begin
            o_off = 5'(w_d6);
        end else begin
            o_off = 5'(w_tgt);
        end
    end

endmodule
